// ----- sv/cna_pkg.sv -----
// Shared widths, types and saturation helpers for the complex number ALU.
package cna_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned ProdWidth = 2 * DataWidth;
  localparam int unsigned SumWidth  = ProdWidth + 1;
  localparam int unsigned RemWidth  = 3 * DataWidth;

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } cna_action_e;

  typedef struct packed {
    cna_action_e                 action;
    logic signed [DataWidth-1:0] a_real;
    logic signed [DataWidth-1:0] a_imag;
    logic signed [DataWidth-1:0] b_real;
    logic signed [DataWidth-1:0] b_imag;
  } cna_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_real;
    logic signed [DataWidth-1:0] res_imag;
    logic                        overflow;
    logic                        div_by_zero;
    logic                        mag_less;
    logic                        mag_greater;
    logic                        parts_equal;
  } cna_out_t;

  typedef struct packed {
    logic                 neg;
    logic                 presat;
    logic [RemWidth-1:0]  rem;
    logic [DataWidth-1:0] quo;
  } cna_lane_t;

  typedef struct packed {
    logic                valid;
    logic                is_div;
    cna_out_t            res;
    logic [RemWidth-1:0] den_sh;
    cna_lane_t           lane_r;
    cna_lane_t           lane_i;
  } cna_pipe_t;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 ovf;
  } cna_sat_t;

  function automatic cna_sat_t sat_wide(input logic signed [SumWidth-1:0] v);
    cna_sat_t                   r;
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    hi = $signed({{(SumWidth-DataWidth+1){1'b0}}, {(DataWidth-1){1'b1}}});
    lo = $signed({{(SumWidth-DataWidth+1){1'b1}}, {(DataWidth-1){1'b0}}});
    if (v > hi) begin
      r.value = hi[DataWidth-1:0];
      r.ovf   = 1'b1;
    end else if (v < lo) begin
      r.value = lo[DataWidth-1:0];
      r.ovf   = 1'b1;
    end else begin
      r.value = v[DataWidth-1:0];
      r.ovf   = 1'b0;
    end
    return r;
  endfunction

  function automatic cna_sat_t sat_quo(input logic neg, input logic presat,
                                       input logic [DataWidth-1:0] q);
    cna_sat_t             r;
    logic [DataWidth-1:0] lim;
    lim = {1'b1, {(DataWidth-1){1'b0}}};
    if (neg) begin
      if (presat || q > lim) begin
        r.value = lim;
        r.ovf   = 1'b1;
      end else begin
        r.value = ~q + DataWidth'(1);
        r.ovf   = 1'b0;
      end
    end else begin
      if (presat || q >= lim) begin
        r.value = lim - DataWidth'(1);
        r.ovf   = 1'b1;
      end else begin
        r.value = q;
        r.ovf   = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/complex_number_alu.sv -----
// Top level of the pipelined complex number ALU.
// The unit takes one item in every cycle and never stalls: busy is always low.
// Each result appears on out_o with done_o high for one cycle, once the item has
// passed the front registers, every divider step and the output register, for every
// action and Q8.8 data alike. The receiver takes the result at the edge that follows.
// The divider makes up most of that path, as it resolves one quotient bit per stage;
// add, subtract and multiply results ride along so that items stay in order.
module complex_number_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cna_pkg::cna_in_t  in_i,
  output logic              done_o,
  output cna_pkg::cna_out_t out_o
);

  localparam int unsigned Steps = cna_pkg::DataWidth;

  cna_pkg::cna_pipe_t pipe [Steps+1];
  cna_pkg::cna_pipe_t last;
  cna_pkg::cna_out_t  out_d, out_q;
  cna_pkg::cna_sat_t  q_r, q_i;
  logic               done_q;

  assign busy = 1'b0;

  cna_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .in_i    (in_i),
    .pipe_o  (pipe[0])
  );

  for (genvar g = 0; g < Steps; g++) begin : g_div
    cna_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (pipe[g]),
      .pipe_o (pipe[g+1])
    );
  end

  assign last = pipe[Steps];

  always_comb begin
    q_r   = cna_pkg::sat_quo(last.lane_r.neg, last.lane_r.presat, last.lane_r.quo);
    q_i   = cna_pkg::sat_quo(last.lane_i.neg, last.lane_i.presat, last.lane_i.quo);
    out_d = last.res;
    if (last.is_div) begin
      out_d.res_real = q_r.value;
      out_d.res_imag = q_i.value;
      out_d.overflow = q_r.ovf | q_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

// ----- sv/cna_front.sv -----
// Front pipeline: products, sums, add/sub/mul saturation, compare flags, divider setup.
module cna_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cna_pkg::cna_in_t    in_i,
  output cna_pkg::cna_pipe_t  pipe_o
);

  localparam int unsigned DW = cna_pkg::DataWidth;
  localparam int unsigned PW = cna_pkg::ProdWidth;
  localparam int unsigned SW = cna_pkg::SumWidth;
  localparam int unsigned RW = cna_pkg::RemWidth;

  logic                 v1_q, v2_q, v3_q;
  cna_pkg::cna_action_e act1_q, act2_q;
  logic                 eq1_q, eq2_q;
  logic signed [DW:0]   sr1_q, si1_q, sr2_q, si2_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0] p_aa_q, p_ab_q, p_ba_q, p_bb_q;
  logic signed [SW-1:0] mul_r_q, mul_i_q, num_r_q, num_i_q, den_q, ma_q, mb_q;
  cna_pkg::cna_pipe_t   pipe_d, pipe_q;

  logic signed [DW:0] sum_r, sum_i;

  always_comb begin
    if (in_i.action == cna_pkg::ActSub) begin
      sum_r = (DW+1)'(in_i.a_real) - (DW+1)'(in_i.b_real);
      sum_i = (DW+1)'(in_i.a_imag) - (DW+1)'(in_i.b_imag);
    end else begin
      sum_r = (DW+1)'(in_i.a_real) + (DW+1)'(in_i.b_real);
      sum_i = (DW+1)'(in_i.a_imag) + (DW+1)'(in_i.b_imag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act1_q <= in_i.action;
    eq1_q  <= (in_i.a_real == in_i.b_real) && (in_i.a_imag == in_i.b_imag);
    sr1_q  <= sum_r;
    si1_q  <= sum_i;
    p_rr_q <= in_i.a_real * in_i.b_real;
    p_ii_q <= in_i.a_imag * in_i.b_imag;
    p_ri_q <= in_i.a_real * in_i.b_imag;
    p_ir_q <= in_i.a_imag * in_i.b_real;
    p_aa_q <= in_i.a_real * in_i.a_real;
    p_ab_q <= in_i.a_imag * in_i.a_imag;
    p_ba_q <= in_i.b_real * in_i.b_real;
    p_bb_q <= in_i.b_imag * in_i.b_imag;

    act2_q  <= act1_q;
    eq2_q   <= eq1_q;
    sr2_q   <= sr1_q;
    si2_q   <= si1_q;
    mul_r_q <= SW'(p_rr_q) - SW'(p_ii_q);
    mul_i_q <= SW'(p_ri_q) + SW'(p_ir_q);
    num_r_q <= SW'(p_rr_q) + SW'(p_ii_q);
    num_i_q <= SW'(p_ir_q) - SW'(p_ri_q);
    den_q   <= SW'(p_ba_q) + SW'(p_bb_q);
    ma_q    <= SW'(p_aa_q) + SW'(p_ab_q);
    mb_q    <= SW'(p_ba_q) + SW'(p_bb_q);
  end

  cna_pkg::cna_sat_t    sat_r, sat_i;
  logic [PW-1:0]        den, mag_r, mag_i;
  logic signed [SW-1:0] neg_r, neg_i;

  always_comb begin
    den   = den_q[PW-1:0];
    neg_r = -num_r_q;
    neg_i = -num_i_q;
    mag_r = num_r_q[SW-1] ? neg_r[PW-1:0] : num_r_q[PW-1:0];
    mag_i = num_i_q[SW-1] ? neg_i[PW-1:0] : num_i_q[PW-1:0];

    if (act2_q == cna_pkg::ActMul) begin
      sat_r = cna_pkg::sat_wide(mul_r_q >>> cna_pkg::FracBits);
      sat_i = cna_pkg::sat_wide(mul_i_q >>> cna_pkg::FracBits);
    end else begin
      sat_r = cna_pkg::sat_wide(SW'(sr2_q));
      sat_i = cna_pkg::sat_wide(SW'(si2_q));
    end

    pipe_d.valid               = v2_q;
    pipe_d.is_div              = (act2_q == cna_pkg::ActDiv) && (den != '0);
    pipe_d.res.mag_less        = ma_q < mb_q;
    pipe_d.res.mag_greater     = ma_q > mb_q;
    pipe_d.res.parts_equal     = eq2_q;
    pipe_d.res.div_by_zero     = (act2_q == cna_pkg::ActDiv) && (den == '0);
    if (act2_q == cna_pkg::ActDiv) begin
      pipe_d.res.res_real = '0;
      pipe_d.res.res_imag = '0;
      pipe_d.res.overflow = 1'b0;
    end else begin
      pipe_d.res.res_real = sat_r.value;
      pipe_d.res.res_imag = sat_i.value;
      pipe_d.res.overflow = sat_r.ovf | sat_i.ovf;
    end
    pipe_d.den_sh        = RW'(den) << (DW - 1);
    pipe_d.lane_r.neg    = num_r_q[SW-1];
    pipe_d.lane_r.rem    = RW'(mag_r) << cna_pkg::FracBits;
    pipe_d.lane_r.presat = (RW'(mag_r) << cna_pkg::FracBits) >= (RW'(den) << DW);
    pipe_d.lane_r.quo    = '0;
    pipe_d.lane_i.neg    = num_i_q[SW-1];
    pipe_d.lane_i.rem    = RW'(mag_i) << cna_pkg::FracBits;
    pipe_d.lane_i.presat = (RW'(mag_i) << cna_pkg::FracBits) >= (RW'(den) << DW);
    pipe_d.lane_i.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= pipe_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  always_comb begin
    pipe_o       = pipe_q;
    pipe_o.valid = v3_q;
  end

endmodule

// ----- sv/cna_div_step.sv -----
// One restoring division step for the real and imaginary quotient lanes.
module cna_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cna_pkg::cna_pipe_t pipe_i,
  output cna_pkg::cna_pipe_t pipe_o
);

  cna_pkg::cna_pipe_t pipe_d, pipe_q;
  logic               valid_q;

  function automatic cna_pkg::cna_lane_t lane_step(input cna_pkg::cna_lane_t l,
      input logic [cna_pkg::RemWidth-1:0] d);
    cna_pkg::cna_lane_t r;
    logic               take;
    r    = l;
    take = l.rem >= d;
    if (take) begin
      r.rem = l.rem - d;
    end
    r.quo = {l.quo[cna_pkg::DataWidth-2:0], take};
    return r;
  endfunction

  always_comb begin
    pipe_d        = pipe_i;
    pipe_d.lane_r = lane_step(pipe_i.lane_r, pipe_i.den_sh);
    pipe_d.lane_i = lane_step(pipe_i.lane_i, pipe_i.den_sh);
    pipe_d.den_sh = pipe_i.den_sh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  always_comb begin
    pipe_o       = pipe_q;
    pipe_o.valid = valid_q;
  end

endmodule

// ----- tb/cna_checker.sv -----
// Checker that predicts each complex ALU result and compares it with the block's output.
module cna_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  cna_pkg::cna_in_t  in_i,
  input  logic              done_i,
  input  cna_pkg::cna_out_t out_i,
  output int                fail_count_o,
  output int                pending_count_o,
  output int                result_count_o
);

  cna_pkg::cna_out_t expected_q[$];

  function automatic logic [15:0] clamp_part(input logic signed [63:0] v, ref logic ovf);
    if (v > 64'sd32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end
    if (v < -64'sd32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic cna_pkg::cna_out_t compute_alu(input cna_pkg::cna_in_t it);
    cna_pkg::cna_out_t r;
    logic signed [63:0] ar, ai, br, bi, sr, si, den, ma, mb;
    logic ovf;
    ar = it.a_real;
    ai = it.a_imag;
    br = it.b_real;
    bi = it.b_imag;
    ovf = 1'b0;
    sr = 0;
    si = 0;
    r = '0;
    den = br * br + bi * bi;
    case (it.action)
      cna_pkg::ActAdd: begin
        sr = ar + br;
        si = ai + bi;
      end
      cna_pkg::ActSub: begin
        sr = ar - br;
        si = ai - bi;
      end
      cna_pkg::ActMul: begin
        sr = (ar * br - ai * bi) >>> cna_pkg::FracBits;
        si = (ar * bi + ai * br) >>> cna_pkg::FracBits;
      end
      default: begin
        if (den != 0) begin
          sr = ((ar * br + ai * bi) * 256) / den;
          si = ((ai * br - ar * bi) * 256) / den;
        end
      end
    endcase
    r.res_real = clamp_part(sr, ovf);
    r.res_imag = clamp_part(si, ovf);
    r.overflow = ovf;
    r.div_by_zero = (it.action == cna_pkg::ActDiv) && (den == 0);
    ma = ar * ar + ai * ai;
    mb = den;
    r.mag_less = ma < mb;
    r.mag_greater = ma > mb;
    r.parts_equal = (ar == br) && (ai == bi);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    cna_pkg::cna_out_t exp_r;
    if (rst_ni) begin
      if (done_i) begin
        result_count_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", {out_i.res_real, out_i.res_imag}, '0);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_i.res_real !== exp_r.res_real)
            report_mismatch("res_real", 32'(out_i.res_real), 32'(exp_r.res_real));
          if (out_i.res_imag !== exp_r.res_imag)
            report_mismatch("res_imag", 32'(out_i.res_imag), 32'(exp_r.res_imag));
          if (out_i.overflow !== exp_r.overflow)
            report_mismatch("overflow", 32'(out_i.overflow), 32'(exp_r.overflow));
          if (out_i.div_by_zero !== exp_r.div_by_zero)
            report_mismatch("div_by_zero", 32'(out_i.div_by_zero),
                            32'(exp_r.div_by_zero));
          if (out_i.mag_less !== exp_r.mag_less)
            report_mismatch("mag_less", 32'(out_i.mag_less), 32'(exp_r.mag_less));
          if (out_i.mag_greater !== exp_r.mag_greater)
            report_mismatch("mag_greater", 32'(out_i.mag_greater),
                            32'(exp_r.mag_greater));
          if (out_i.parts_equal !== exp_r.parts_equal)
            report_mismatch("parts_equal", 32'(out_i.parts_equal),
                            32'(exp_r.parts_equal));
        end
      end
      if (start_i && !busy_i) expected_q.push_back(compute_alu(in_i));
    end
    pending_count_o = expected_q.size();
  end
endmodule

// ----- tb/tb_complex_number_alu.sv -----
// Testbench top that drives random and directed complex ALU items and reports the verdict.
module tb_complex_number_alu;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cna_pkg::cna_in_t  in_i;
  logic              done;
  cna_pkg::cna_out_t out_o;
  int                fail_count;
  int                pending_count;
  int                result_count;
  int                sent_count;

  complex_number_alu u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done),
    .out_o (out_o)
  );

  cna_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .in_i           (in_i),
    .done_i         (done),
    .out_i          (out_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .result_count_o (result_count)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 1023)) - 512);
      5, 6: return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one item and holds it until the block takes it.
  task automatic send_item(input cna_pkg::cna_action_e act, input logic [15:0] ar,
                           input logic [15:0] ai, input logic [15:0] br,
                           input logic [15:0] bi);
    start <= 1'b1;
    in_i.action <= act;
    in_i.a_real <= ar;
    in_i.a_imag <= ai;
    in_i.b_real <= br;
    in_i.b_imag <= bi;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      in_i.action <= cna_pkg::cna_action_e'($urandom_range(0, 3));
      in_i.a_real <= 16'($urandom);
      in_i.a_imag <= 16'($urandom);
      in_i.b_real <= 16'($urandom);
      in_i.b_imag <= 16'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    #200000000;
    $display("complex_number_alu verification failed");
    $finish;
  end

  initial begin
    logic [15:0] x, y;
    int waited;
    sent_count = 0;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int a = 0; a < 4; a++) begin
      send_item(cna_pkg::cna_action_e'(a), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_item(cna_pkg::cna_action_e'(a), 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      send_item(cna_pkg::cna_action_e'(a), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(cna_pkg::cna_action_e'(a), 16'h0100, 16'hff00, 16'h0000, 16'h0001);
    end
    send_item(cna_pkg::ActDiv, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_item(cna_pkg::ActDiv, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(cna_pkg::ActDiv, 16'h7fff, 16'h0000, 16'h0001, 16'h0000);
    send_item(cna_pkg::ActMul, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_item(cna_pkg::ActMul, 16'h0003, 16'h0004, 16'h0005, 16'h0000);
    send_item(cna_pkg::ActAdd, 16'h0300, 16'h0400, 16'hfb00, 16'h0000);
    send_item(cna_pkg::ActSub, 16'h0300, 16'h0400, 16'h0400, 16'h0300);
    for (int k = 0; k < 2000; k++) begin
      x = pick_part();
      y = pick_part();
      case ($urandom_range(0, 9))
        0: send_item(cna_pkg::cna_action_e'($urandom_range(0, 3)), x, y, x, y);
        1: send_item(cna_pkg::cna_action_e'($urandom_range(0, 3)), x, y, y, x);
        2: send_item(cna_pkg::ActDiv, x, y, 16'h0000, 16'h0000);
        3: send_item(cna_pkg::cna_action_e'($urandom_range(0, 3)), x, y, 16'(-x), y);
        default: send_item(cna_pkg::cna_action_e'($urandom_range(0, 3)), pick_part(),
                           pick_part(), pick_part(), pick_part());
      endcase
      idle_gap();
    end
    start <= 1'b0;
    waited = 0;
    while (pending_count != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items over all four actions, %0d results checked.",
             sent_count, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("complex_number_alu verification clean");
    end else begin
      $display("complex_number_alu verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/cna_pkg.sv
sv/cna_front.sv
sv/cna_div_step.sv
sv/complex_number_alu.sv
tb/cna_checker.sv
tb/tb_complex_number_alu.sv
